// ===== rtl/pressure_sensor_depth_compensation_top_macros.svh =====
// Assertion macros used by the checker file psdc_chk.sv.
`ifndef PRESSURE_SENSOR_DEPTH_COMPENSATION_TOP_MACROS_SVH
`define PRESSURE_SENSOR_DEPTH_COMPENSATION_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define PSDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psdc: same-cycle check failed");

// Next-cycle implication, off while reset is asserted
`define PSDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psdc: next-cycle check failed");

// Condition that must hold in the cycle after reset is sampled
`define PSDC_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
        else $error("psdc: post-reset check failed");

`endif

// ===== rtl/psdc_pkg.sv =====
package psdc_pkg;

    // Field and register widths
    localparam int D_W       = 24;
    localparam int CAL_W     = 16;
    localparam int PM_W      = 16;
    localparam int DEPTH_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Number of register stages in the datapath, output register included
    localparam int NSTG = 18;

    // Internal datapath widths
    localparam int DT_W   = D_W + 1;          // D2 - C5*256
    localparam int MP_W   = DT_W + CAL_W + 1; // dT times a calibration word
    localparam int E_W    = 19;               // TEMP - 2000
    localparam int ESQ_W  = 34;               // (TEMP - 2000)^2
    localparam int OFF_W  = 38;
    localparam int SENS_W = 37;
    localparam int LO_W   = 18;               // low slice of SENS for split multiply
    localparam int PPL_W  = D_W + LO_W;
    localparam int PPH_W  = D_W + 1 + SENS_W - LO_W;
    localparam int PROD_W = 62;
    localparam int Y_W    = 42;
    localparam int XM_W   = 27;
    localparam int QP_W   = 54;
    localparam int Q_W    = 21;
    localparam int P_W    = Q_W + 1;
    localparam int G_W    = 29;
    localparam int GM_W   = G_W - 1;
    localparam int TP_W   = 60;
    localparam int NN_W   = 58;
    localparam int T_W    = 28;
    localparam int G6_W   = 31;

    // Shift amounts of the compensation formulas
    localparam int SH_TEMP  = 23;
    localparam int SH_OFF   = 6;
    localparam int SH_SENS  = 7;
    localparam int SH_C2    = 17;
    localparam int SH_C1    = 16;
    localparam int SH_ESQ31 = 3;
    localparam int SH_ESQ63 = 5;
    localparam int SH_P1    = 21;
    localparam int SH_P2    = 15;

    // Divide by 100 through a reciprocal
    localparam int             RECIP_SH = 33;
    localparam logic [6:0]     DIV_P    = 7'd100;
    localparam logic [XM_W-1:0] RECIP100 = XM_W'((64'd1 << RECIP_SH) / 100);

    // Atmosphere and depth scale: depth = gauge_pa * 65536 * 100000 / 1009104285
    localparam int      ATM_PA     = 101300;
    localparam int      ATM_MBAR   = ATM_PA / 100;
    localparam longint  DEPTH_NUM  = 64'sd6553600000;
    localparam longint  DEPTH_DEN  = 64'sd1009104285;
    localparam longint  DEPTH_INT  = DEPTH_NUM / DEPTH_DEN;
    localparam longint  DEPTH_REM  = DEPTH_NUM % DEPTH_DEN;
    localparam longint  DEPTH_HALF = DEPTH_DEN / 2;
    localparam int      DEPTH_SH   = 32;
    localparam longint  DEPTH_F    = (DEPTH_REM << DEPTH_SH) / DEPTH_DEN;
    localparam longint  DEPTH_FB   = (DEPTH_HALF << DEPTH_SH) / DEPTH_DEN;

    localparam logic [2:0]  DEPTH_INT_K  = 3'(DEPTH_INT);
    localparam logic [28:0] DEPTH_REM_K  = 29'(DEPTH_REM);
    localparam logic [28:0] DEPTH_HALF_K = 29'(DEPTH_HALF);
    localparam logic [29:0] DEPTH_DEN_K  = 30'(DEPTH_DEN);
    localparam logic [31:0] DEPTH_F_K    = 32'(DEPTH_F);
    localparam logic [31:0] DEPTH_FB_K   = 32'(DEPTH_FB);

    // Calibration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    // Pipeline control from the top level
    typedef struct packed {
        logic adv;     // all stages shift
        logic in_vld;  // an item enters with the shift
    } t_pipe_ctl;

endpackage

// ===== rtl/psdc_in_if.sv =====
interface psdc_in_if;
    import psdc_pkg::*;

    logic           valid;
    logic           ready;
    logic [D_W-1:0] raw_pressure;
    logic [D_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== rtl/psdc_out_if.sv =====
interface psdc_out_if;
    import psdc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [PM_W-1:0]    pressure_mbar;
    logic signed [DEPTH_W-1:0] depth_q16;

    modport source (output valid, output pressure_mbar, output depth_q16, input ready);
    modport sink   (input valid, input pressure_mbar, input depth_q16, output ready);
endinterface

// ===== rtl/pressure_sensor_depth_compensation_top.sv =====
// Throughput: one item per cycle; the whole pipeline holds while the output
//   register is full and not taken, so input ready is high while it is empty or being taken.
// Reset (synchronous, active low) clears the calibration registers and all
//   stage valid bits; stage payload registers are not reset.
module pressure_sensor_depth_compensation_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    psdc_in_if.sink                        i_in,
    psdc_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [psdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [psdc_pkg::CAL_W-1:0]     i_cfg_wdata
);
    import psdc_pkg::*;

    t_cal      r_cal, n_cal;
    t_pipe_ctl w_ctl;
    logic      w_out_vld;

    // Calibration register writes
    always_comb begin
        n_cal = r_cal;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_C1:  n_cal.c1 = i_cfg_wdata;
                CFG_C2:  n_cal.c2 = i_cfg_wdata;
                CFG_C3:  n_cal.c3 = i_cfg_wdata;
                CFG_C4:  n_cal.c4 = i_cfg_wdata;
                CFG_C5:  n_cal.c5 = i_cfg_wdata;
                CFG_C6:  n_cal.c6 = i_cfg_wdata;
                default: n_cal = r_cal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    // Shift whenever the output register is empty or being drained
    assign w_ctl.adv    = !w_out_vld || o_out.ready;
    assign w_ctl.in_vld = i_in.valid;
    assign i_in.ready   = w_ctl.adv;
    assign o_out.valid  = w_out_vld;

    psdc_pipe u_pipe (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .i_cal             (r_cal),
        .i_raw_pressure    (i_in.raw_pressure),
        .i_raw_temperature (i_in.raw_temperature),
        .o_valid           (w_out_vld),
        .o_pressure_mbar   (o_out.pressure_mbar),
        .o_depth_q16       (o_out.depth_q16)
    );

endmodule

// ===== rtl/psdc_pipe.sv =====
module psdc_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psdc_pkg::t_pipe_ctl                 i_ctl,
    input  psdc_pkg::t_cal                      i_cal,
    input  logic [psdc_pkg::D_W-1:0]            i_raw_pressure,
    input  logic [psdc_pkg::D_W-1:0]            i_raw_temperature,
    output logic                                o_valid,
    output logic signed [psdc_pkg::PM_W-1:0]    o_pressure_mbar,
    output logic signed [psdc_pkg::DEPTH_W-1:0] o_depth_q16
);
    import psdc_pkg::*;

    // Saturation and gauge constants
    localparam logic signed [P_W-1:0] P_SAT_HI = P_W'(2 ** (PM_W - 1) - 1);
    localparam logic signed [P_W-1:0] P_SAT_LO = P_W'(-(2 ** (PM_W - 1)));
    localparam logic signed [G_W-1:0] G_SCALE  = G_W'(DIV_P);
    localparam logic signed [G_W-1:0] G_ATM    = G_W'(ATM_PA);

    logic [NSTG-1:0] r_vld;

    // Stage registers
    logic [D_W-1:0]            r1_d1, r2_d1, r3_d1, r4_d1, r5_d1;
    logic signed [DT_W-1:0]    r1_dt;
    logic signed [MP_W-1:0]    r2_dtc6, r2_dtc4, r2_dtc3;
    logic signed [E_W-1:0]     r3_e;
    logic                      r3_cold, r4_cold;
    logic signed [OFF_W-1:0]   r3_off1, r4_off1, r5_off2, r6_off2, r7_off2;
    logic signed [SENS_W-1:0]  r3_sens1, r4_sens1, r5_sens2;
    logic [ESQ_W-1:0]          r4_esq;
    logic [PPL_W-1:0]          r6_pp_lo;
    logic signed [PPH_W-1:0]   r6_pp_hi;
    logic signed [PROD_W-1:0]  r7_prod;
    logic signed [Y_W-1:0]     r8_y;
    logic [XM_W-1:0]           r9_xm, r10_xm;
    logic                      r9_neg, r10_neg, r11_neg;
    logic [Q_W-1:0]            r10_q0, r11_q;
    logic signed [P_W-1:0]     r12_p;
    logic signed [PM_W-1:0]    r13_pm, r14_pm, r15_pm, r16_pm, r17_pm, r18_pm;
    logic signed [G_W-1:0]     r13_g;
    logic                      r14_gs, r15_gs, r16_gs, r17_gs;
    logic [GM_W-1:0]           r14_gm;
    logic [G6_W-1:0]           r15_g6, r16_g6;
    logic [T_W-1:0]            r15_t0, r16_t0;
    logic [NN_W-1:0]           r15_nn, r16_nn, r16_pp;
    logic [DEPTH_W-1:0]        r17_mag;
    logic signed [DEPTH_W-1:0] r18_depth;

    // Next values
    logic signed [DT_W-1:0]     n1_dt;
    logic signed [MP_W-1:0]     n2_dtc6, n2_dtc4, n2_dtc3;
    logic signed [MP_W-1:0]     n3_q6, n3_q4, n3_q3;
    logic signed [E_W-1:0]      n3_e;
    logic signed [OFF_W-1:0]    n3_off1, n5_off2;
    logic signed [SENS_W-1:0]   n3_sens1, n5_sens2;
    logic signed [2*E_W-1:0]    n4_sq;
    logic [ESQ_W+4:0]           n5_m31;
    logic [ESQ_W+5:0]           n5_m63;
    logic [ESQ_W+4-SH_ESQ31:0]  n5_cor_off;
    logic [ESQ_W+5-SH_ESQ63:0]  n5_cor_sens;
    logic [PPL_W-1:0]           n6_pp_lo;
    logic signed [PPH_W-1:0]    n6_pp_hi;
    logic signed [PROD_W-1:0]   n7_prod, n8_q;
    logic signed [Y_W-1:0]      n8_y;
    logic [Y_W-1:0]             n9_ym;
    logic [XM_W-1:0]            n9_xm;
    logic [QP_W-1:0]            n10_qp;
    logic [Q_W-1:0]             n10_q0, n11_q;
    logic [XM_W:0]              n11_r;
    logic signed [P_W-1:0]      n12_p;
    logic signed [PM_W-1:0]     n13_pm;
    logic signed [G_W-1:0]      n13_g;
    logic [GM_W-1:0]            n14_gm;
    logic [NN_W-1:0]            n15_nn, n16_pp, n17_rr;
    logic [TP_W-1:0]            n15_tp;
    logic [T_W-1:0]             n15_t0;
    logic [G6_W-1:0]            n15_g6;
    logic [DEPTH_W-1:0]         n17_mag;
    logic signed [DEPTH_W-1:0]  n18_depth;

    // Valid bits shift with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_ctl.in_vld};
        end
    end

    // Datapath
    always_comb begin
        // s1: dT
        n1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.c5, 8'b0});

        // s2: dT products
        n2_dtc6 = MP_W'(r1_dt) * MP_W'($signed({1'b0, i_cal.c6}));
        n2_dtc4 = MP_W'(r1_dt) * MP_W'($signed({1'b0, i_cal.c4}));
        n2_dtc3 = MP_W'(r1_dt) * MP_W'($signed({1'b0, i_cal.c3}));

        // s3: truncating shifts, first-order OFF and SENS
        n3_q6 = (r2_dtc6 + $signed({{(MP_W-SH_TEMP){1'b0}}, {SH_TEMP{r2_dtc6[MP_W-1]}}}))
                >>> SH_TEMP;
        n3_q4 = (r2_dtc4 + $signed({{(MP_W-SH_OFF){1'b0}}, {SH_OFF{r2_dtc4[MP_W-1]}}}))
                >>> SH_OFF;
        n3_q3 = (r2_dtc3 + $signed({{(MP_W-SH_SENS){1'b0}}, {SH_SENS{r2_dtc3[MP_W-1]}}}))
                >>> SH_SENS;
        n3_e     = n3_q6[E_W-1:0];
        n3_off1  = $signed({{(OFF_W-CAL_W-SH_C2){1'b0}}, i_cal.c2, {SH_C2{1'b0}}})
                   + OFF_W'(n3_q4);
        n3_sens1 = $signed({{(SENS_W-CAL_W-SH_C1){1'b0}}, i_cal.c1, {SH_C1{1'b0}}})
                   + SENS_W'(n3_q3);

        // s4: square of the temperature offset
        n4_sq = (2*E_W)'(r3_e) * (2*E_W)'(r3_e);

        // s5: low-temperature correction, 31*e^2/8 and 63*e^2/32
        n5_m31      = {r4_esq, 5'b0} - (ESQ_W+5)'(r4_esq);
        n5_m63      = {r4_esq, 6'b0} - (ESQ_W+6)'(r4_esq);
        n5_cor_off  = n5_m31[ESQ_W+4:SH_ESQ31] & {(ESQ_W+5-SH_ESQ31){r4_cold}};
        n5_cor_sens = n5_m63[ESQ_W+5:SH_ESQ63] & {(ESQ_W+6-SH_ESQ63){r4_cold}};
        n5_off2     = r4_off1 - $signed(OFF_W'(n5_cor_off));
        n5_sens2    = r4_sens1 - $signed(SENS_W'(n5_cor_sens));

        // s6: D1*SENS as two partial products
        n6_pp_lo = PPL_W'(r5_d1) * PPL_W'(r5_sens2[LO_W-1:0]);
        n6_pp_hi = PPH_W'($signed({1'b0, r5_d1})) * PPH_W'($signed(r5_sens2[SENS_W-1:LO_W]));

        // s7: recombine
        n7_prod = (PROD_W'(r6_pp_hi) <<< LO_W) + $signed(PROD_W'(r6_pp_lo));

        // s8: /2^21 toward zero, minus OFF
        n8_q = (r7_prod + $signed({{(PROD_W-SH_P1){1'b0}}, {SH_P1{r7_prod[PROD_W-1]}}}))
               >>> SH_P1;
        n8_y = Y_W'(n8_q) - Y_W'(r7_off2);

        // s9: magnitude of y/2^15 toward zero
        n9_ym = r8_y[Y_W-1] ? Y_W'(-r8_y) : Y_W'(r8_y);
        n9_xm = XM_W'(n9_ym >> SH_P2);

        // s10: quotient estimate by 100, may be one low
        n10_qp = QP_W'(r9_xm) * QP_W'(RECIP100);
        n10_q0 = Q_W'(n10_qp >> RECIP_SH);

        // s11: remainder check
        n11_r = (XM_W+1)'(r10_xm) - (XM_W+1)'(r10_q0) * (XM_W+1)'(DIV_P);
        n11_q = r10_q0 + Q_W'(n11_r >= (XM_W+1)'(DIV_P));

        // s12: signed pressure
        n12_p = r11_neg ? -$signed({1'b0, r11_q}) : $signed({1'b0, r11_q});

        // s13: saturate mbar, gauge pressure in Pa
        priority if (r12_p > P_SAT_HI) begin
            n13_pm = P_SAT_HI[PM_W-1:0];
        end else if (r12_p < P_SAT_LO) begin
            n13_pm = P_SAT_LO[PM_W-1:0];
        end else begin
            n13_pm = r12_p[PM_W-1:0];
        end
        n13_g = G_W'(r12_p) * G_SCALE - G_ATM;

        // s14: gauge magnitude
        n14_gm = r13_g[G_W-1] ? GM_W'(-r13_g) : GM_W'(r13_g);

        // s15: depth = INT*|g| + floor((|g|*REM + DEN/2)/DEN), estimate the fraction part
        n15_nn = NN_W'(r14_gm) * NN_W'(DEPTH_REM_K) + NN_W'(DEPTH_HALF_K);
        n15_tp = TP_W'(r14_gm) * TP_W'(DEPTH_F_K) + TP_W'(DEPTH_FB_K);
        n15_t0 = T_W'(n15_tp >> DEPTH_SH);
        n15_g6 = G6_W'(r14_gm) * G6_W'(DEPTH_INT_K);

        // s16: back-multiply the estimate
        n16_pp = NN_W'(r15_t0) * NN_W'(DEPTH_DEN_K);

        // s17: correct the estimate by one where the remainder allows
        n17_rr  = r16_nn - r16_pp;
        n17_mag = DEPTH_W'(r16_g6) + DEPTH_W'(r16_t0)
                  + DEPTH_W'(n17_rr >= NN_W'(DEPTH_DEN_K));

        // s18: apply sign; magnitude stays below 2^30, no saturation needed
        n18_depth = r17_gs ? -$signed(r17_mag) : $signed(r17_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r1_d1     <= i_raw_pressure;
            r1_dt     <= n1_dt;
            r2_d1     <= r1_d1;
            r2_dtc6   <= n2_dtc6;
            r2_dtc4   <= n2_dtc4;
            r2_dtc3   <= n2_dtc3;
            r3_d1     <= r2_d1;
            r3_e      <= n3_e;
            r3_cold   <= n3_e[E_W-1];
            r3_off1   <= n3_off1;
            r3_sens1  <= n3_sens1;
            r4_d1     <= r3_d1;
            r4_esq    <= n4_sq[ESQ_W-1:0];
            r4_cold   <= r3_cold;
            r4_off1   <= r3_off1;
            r4_sens1  <= r3_sens1;
            r5_d1     <= r4_d1;
            r5_off2   <= n5_off2;
            r5_sens2  <= n5_sens2;
            r6_pp_lo  <= n6_pp_lo;
            r6_pp_hi  <= n6_pp_hi;
            r6_off2   <= r5_off2;
            r7_prod   <= n7_prod;
            r7_off2   <= r6_off2;
            r8_y      <= n8_y;
            r9_xm     <= n9_xm;
            r9_neg    <= r8_y[Y_W-1];
            r10_xm    <= r9_xm;
            r10_q0    <= n10_q0;
            r10_neg   <= r9_neg;
            r11_q     <= n11_q;
            r11_neg   <= r10_neg;
            r12_p     <= n12_p;
            r13_pm    <= n13_pm;
            r13_g     <= n13_g;
            r14_pm    <= r13_pm;
            r14_gm    <= n14_gm;
            r14_gs    <= r13_g[G_W-1];
            r15_pm    <= r14_pm;
            r15_gs    <= r14_gs;
            r15_nn    <= n15_nn;
            r15_t0    <= n15_t0;
            r15_g6    <= n15_g6;
            r16_pm    <= r15_pm;
            r16_gs    <= r15_gs;
            r16_nn    <= r15_nn;
            r16_t0    <= r15_t0;
            r16_g6    <= r15_g6;
            r16_pp    <= n16_pp;
            r17_pm    <= r16_pm;
            r17_gs    <= r16_gs;
            r17_mag   <= n17_mag;
            r18_pm    <= r17_pm;
            r18_depth <= n18_depth;
        end
    end

    assign o_valid         = r_vld[NSTG-1];
    assign o_pressure_mbar = r18_pm;
    assign o_depth_q16     = r18_depth;

endmodule

// ===== rtl/psdc_chk.sv =====
`include "pressure_sensor_depth_compensation_top_macros.svh"

module psdc_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [psdc_pkg::PM_W-1:0]    i_pressure_mbar,
    input logic signed [psdc_pkg::DEPTH_W-1:0] i_depth_q16
);
    import psdc_pkg::*;

    logic w_in_seen;
    assign w_in_seen = i_in_valid || !i_in_valid;

    // No result shows right after reset
    `PSDC_ASSERT_RST(a_rst_out_idle, i_clk, i_rst_n, !i_out_valid)

    // A result that is not taken holds
    `PSDC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pressure_mbar) && $stable(i_depth_q16))

    // A blocked output stalls the input side
    `PSDC_ASSERT_IMP(a_stall_in, i_clk, i_rst_n, w_in_seen && i_out_valid && !i_out_ready, !i_in_ready)

    // Depth sign agrees with pressure against one atmosphere, saturated or not
    `PSDC_ASSERT_IMP(a_depth_sign, i_clk, i_rst_n, i_out_valid, ((i_pressure_mbar > ATM_MBAR) == (i_depth_q16 > 0)) && ((i_pressure_mbar < ATM_MBAR) == (i_depth_q16 < 0)))

endmodule

bind pressure_sensor_depth_compensation_top psdc_chk u_psdc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_pressure_mbar (o_out.pressure_mbar),
    .i_depth_q16     (o_out.depth_q16)
);
